>>> rtl/mx2_pkg.sv
// Shared types, constants and helpers for the 2x2 matrix arithmetic unit.
package mx2_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int TOL_W  = 17;
    localparam int OP_W   = 4;
    localparam int LANES  = 4;

    localparam int PROD_W = 2 * DATA_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int WIDE_W = SUM_W - FRAC_W;
    localparam int NX_W   = DATA_W + 1;
    localparam int MAG_W  = NX_W - 1 + FRAC_W;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

    localparam logic [OP_W-1:0] OP_ADD    = OP_W'(0);
    localparam logic [OP_W-1:0] OP_SUB    = OP_W'(1);
    localparam logic [OP_W-1:0] OP_SCALE  = OP_W'(2);
    localparam logic [OP_W-1:0] OP_DIVIDE = OP_W'(3);
    localparam logic [OP_W-1:0] OP_MATMUL = OP_W'(4);
    localparam logic [OP_W-1:0] OP_MATVEC = OP_W'(5);
    localparam logic [OP_W-1:0] OP_DET    = OP_W'(6);
    localparam logic [OP_W-1:0] OP_TRANSP = OP_W'(7);
    localparam logic [OP_W-1:0] OP_INVERT = OP_W'(8);

    localparam logic signed [WIDE_W-1:0] SAT_HI = WIDE_W'({1'b0, {(DATA_W-1){1'b1}}});
    localparam logic signed [WIDE_W-1:0] SAT_LO = ~SAT_HI;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        data_t           a_r1c1;
        data_t           a_r2c1;
        data_t           a_r1c2;
        data_t           a_r2c2;
        data_t           b_r1c1;
        data_t           b_r2c1;
        data_t           b_r1c2;
        data_t           b_r2c2;
    } in_item_t;

    typedef struct packed {
        data_t r_r1c1;
        data_t r_r2c1;
        data_t r_r1c2;
        data_t r_r2c2;
        data_t det_value;
        logic  singular;
        logic  saturated;
    } out_item_t;

    typedef struct packed {
        logic add;
        logic sub;
        logic scale;
        logic divide;
        logic matmul;
        logic matvec;
        logic det_op;
        logic transp;
        logic invert;
    } cls_t;

    typedef struct packed {
        cls_t     cls;
        in_item_t item;
    } cmd_t;

    typedef struct packed {
        logic [LANES-1:0][WIDE_W-1:0] lane;
        logic [LANES-1:0]             q_neg;
        logic                         use_q;
        logic                         sing;
        logic [WIDE_W-1:0]            det;
    } div_side_t;

    typedef struct packed {
        data_t val;
        logic  clamp;
    } sat_t;

    function automatic sat_t sat_f(input logic signed [WIDE_W-1:0] v);
        sat_t r;
        r.clamp = 1'b0;
        r.val   = v[DATA_W-1:0];
        if (v > SAT_HI)
        begin
            r.clamp = 1'b1;
            r.val   = SAT_HI[DATA_W-1:0];
        end
        else if (v < SAT_LO)
        begin
            r.clamp = 1'b1;
            r.val   = SAT_LO[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/mx2_front.sv
// Front end: takes requests and classifies the operation code.
module mx2_front import mx2_pkg::*;
(
    input  logic     in_valid,
    input  in_item_t in_data,
    output logic     in_stall,
    input  logic     q_full,
    output logic     push,
    output cmd_t     cmd
);

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        cmd.item = in_data;
        cmd.cls  = '0;
        case (in_data.op)
            OP_ADD:    cmd.cls.add    = 1'b1;
            OP_SUB:    cmd.cls.sub    = 1'b1;
            OP_SCALE:  cmd.cls.scale  = 1'b1;
            OP_DIVIDE: cmd.cls.divide = 1'b1;
            OP_MATMUL: cmd.cls.matmul = 1'b1;
            OP_MATVEC: cmd.cls.matvec = 1'b1;
            OP_DET:    cmd.cls.det_op = 1'b1;
            OP_TRANSP: cmd.cls.transp = 1'b1;
            OP_INVERT: cmd.cls.invert = 1'b1;
            default:   cmd.cls        = '0;
        endcase
    end

endmodule

>>> rtl/mx2_queue.sv
// Short request queue between the front end and the execution pipeline.
module mx2_queue import mx2_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic q_valid,
    output cmd_t q_data
);

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == QCNT_W'(QDEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/mx2_div.sv
// Pipelined four-lane restoring divider, one quotient bit per stage.
module mx2_div import mx2_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [MAG_W-1:0]            in_den,
    input  logic [LANES-1:0][MAG_W-1:0] in_num,
    input  div_side_t                   in_side,
    output logic                        out_valid,
    output logic [LANES-1:0][MAG_W-1:0] out_quo,
    output div_side_t                   out_side
);

    logic [MAG_W-1:0]            vld_reg;
    logic [MAG_W-1:0]            den_reg  [MAG_W];
    logic [LANES-1:0][MAG_W-1:0] rem_reg  [MAG_W];
    logic [LANES-1:0][MAG_W-1:0] num_reg  [MAG_W];
    logic [LANES-1:0][MAG_W-1:0] quo_reg  [MAG_W];
    div_side_t                   side_reg [MAG_W];

    logic [MAG_W-1:0]            den_src  [MAG_W];
    logic [LANES-1:0][MAG_W-1:0] rem_src  [MAG_W];
    logic [LANES-1:0][MAG_W-1:0] num_src  [MAG_W];
    logic [LANES-1:0][MAG_W-1:0] quo_src  [MAG_W];

    logic [LANES-1:0][MAG_W-1:0] rem_next [MAG_W];
    logic [LANES-1:0][MAG_W-1:0] num_next [MAG_W];
    logic [LANES-1:0][MAG_W-1:0] quo_next [MAG_W];

    always_comb
    begin
        den_src[0] = in_den;
        rem_src[0] = '0;
        num_src[0] = in_num;
        quo_src[0] = '0;
        for (int s = 1; s < MAG_W; s++)
        begin
            den_src[s] = den_reg[s-1];
            rem_src[s] = rem_reg[s-1];
            num_src[s] = num_reg[s-1];
            quo_src[s] = quo_reg[s-1];
        end
    end

    always_comb
    begin
        logic [MAG_W:0] trial;
        logic [MAG_W:0] diff;
        for (int s = 0; s < MAG_W; s++)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                trial = {rem_src[s][k], num_src[s][k][MAG_W-1]};
                diff  = trial - {1'b0, den_src[s]};
                num_next[s][k] = {num_src[s][k][MAG_W-2:0], 1'b0};
                if (diff[MAG_W])
                begin
                    rem_next[s][k] = trial[MAG_W-1:0];
                    quo_next[s][k] = {quo_src[s][k][MAG_W-2:0], 1'b0};
                end
                else
                begin
                    rem_next[s][k] = diff[MAG_W-1:0];
                    quo_next[s][k] = {quo_src[s][k][MAG_W-2:0], 1'b1};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[MAG_W-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int s = 1; s < MAG_W; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
            for (int s = 0; s < MAG_W; s++)
            begin
                den_reg[s] <= den_src[s];
                rem_reg[s] <= rem_next[s];
                num_reg[s] <= num_next[s];
                quo_reg[s] <= quo_next[s];
            end
        end
    end

    assign out_valid = vld_reg[MAG_W-1];
    assign out_quo   = quo_reg[MAG_W-1];
    assign out_side  = side_reg[MAG_W-1];

endmodule

>>> rtl/mx2_back.sv
// Execution pipeline: products, sums, divider set-up, division and saturation.
module mx2_back import mx2_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [TOL_W-1:0] tol,
    input  logic             q_valid,
    input  cmd_t             q_cmd,
    output logic             pop,
    input  logic             out_stall,
    output logic             out_valid,
    output out_item_t        out_data
);

    logic en;
    logic out_valid_reg;
    out_item_t out_data_reg;

    assign en  = !out_valid_reg || !out_stall;
    assign pop = en && q_valid;

    // stage 1: products
    data_t fa [LANES];
    data_t fb [LANES];
    data_t ga [LANES];
    data_t gb [LANES];

    logic                     s1_vld_reg;
    cmd_t                     s1_cmd_reg;
    logic signed [PROD_W-1:0] s1_pa_reg [LANES];
    logic signed [PROD_W-1:0] s1_pb_reg [LANES];
    logic signed [PROD_W-1:0] s1_pd1_reg;
    logic signed [PROD_W-1:0] s1_pd2_reg;

    always_comb
    begin
        ga[0] = q_cmd.item.a_r1c2;
        ga[1] = q_cmd.item.a_r2c2;
        ga[2] = q_cmd.item.a_r1c2;
        ga[3] = q_cmd.item.a_r2c2;
        gb[0] = q_cmd.item.b_r2c1;
        gb[1] = q_cmd.item.b_r2c1;
        gb[2] = q_cmd.item.b_r2c2;
        gb[3] = q_cmd.item.b_r2c2;
        if (q_cmd.cls.scale)
        begin
            fa[0] = q_cmd.item.a_r1c1;
            fa[1] = q_cmd.item.a_r2c1;
            fa[2] = q_cmd.item.a_r1c2;
            fa[3] = q_cmd.item.a_r2c2;
            for (int k = 0; k < LANES; k++)
            begin
                fb[k] = q_cmd.item.b_r1c1;
            end
        end
        else
        begin
            fa[0] = q_cmd.item.a_r1c1;
            fa[1] = q_cmd.item.a_r2c1;
            fa[2] = q_cmd.item.a_r1c1;
            fa[3] = q_cmd.item.a_r2c1;
            fb[0] = q_cmd.item.b_r1c1;
            fb[1] = q_cmd.item.b_r1c1;
            fb[2] = q_cmd.item.b_r1c2;
            fb[3] = q_cmd.item.b_r1c2;
        end
    end

    // stage 2: sums and per-lane values
    cls_t                     c2;
    in_item_t                 it2;
    logic signed [SUM_W-1:0]  sum2 [LANES];
    logic signed [SUM_W-1:0]  dsum2;
    logic signed [WIDE_W-1:0] mm2 [LANES];
    logic signed [WIDE_W-1:0] det2;
    data_t                    ax2 [LANES];
    data_t                    bx2 [LANES];
    data_t                    tx2 [LANES];
    logic signed [WIDE_W-1:0] lane2 [LANES];
    logic signed [NX_W-1:0]   nx2 [LANES];

    logic                     s2_vld_reg;
    cls_t                     s2_cls_reg;
    data_t                    s2_b11_reg;
    logic signed [WIDE_W-1:0] s2_lane_reg [LANES];
    logic signed [WIDE_W-1:0] s2_det_reg;
    logic signed [NX_W-1:0]   s2_nx_reg [LANES];

    assign c2  = s1_cmd_reg.cls;
    assign it2 = s1_cmd_reg.item;

    always_comb
    begin
        ax2[0] = it2.a_r1c1;
        ax2[1] = it2.a_r2c1;
        ax2[2] = it2.a_r1c2;
        ax2[3] = it2.a_r2c2;
        bx2[0] = it2.b_r1c1;
        bx2[1] = it2.b_r2c1;
        bx2[2] = it2.b_r1c2;
        bx2[3] = it2.b_r2c2;
        tx2[0] = it2.a_r1c1;
        tx2[1] = it2.a_r1c2;
        tx2[2] = it2.a_r2c1;
        tx2[3] = it2.a_r2c2;

        dsum2 = SUM_W'(s1_pd1_reg) - SUM_W'(s1_pd2_reg);
        det2  = dsum2[SUM_W-1:FRAC_W];

        for (int k = 0; k < LANES; k++)
        begin
            sum2[k] = SUM_W'(s1_pa_reg[k]) + (c2.scale ? '0 : SUM_W'(s1_pb_reg[k]));
            mm2[k]  = sum2[k][SUM_W-1:FRAC_W];
            if (c2.add)
                lane2[k] = WIDE_W'(ax2[k]) + WIDE_W'(bx2[k]);
            else if (c2.sub)
                lane2[k] = WIDE_W'(ax2[k]) - WIDE_W'(bx2[k]);
            else if (c2.scale || c2.matmul)
                lane2[k] = mm2[k];
            else if (c2.matvec)
                lane2[k] = (k < 2) ? mm2[k] : '0;
            else if (c2.det_op)
                lane2[k] = (k == 0) ? det2 : '0;
            else if (c2.transp)
                lane2[k] = WIDE_W'(tx2[k]);
            else if (c2.divide || c2.invert)
                lane2[k] = WIDE_W'(ax2[k]);
            else
                lane2[k] = '0;
        end

        if (c2.invert)
        begin
            nx2[0] = NX_W'(it2.a_r2c2);
            nx2[1] = -NX_W'(it2.a_r2c1);
            nx2[2] = -NX_W'(it2.a_r1c2);
            nx2[3] = NX_W'(it2.a_r1c1);
        end
        else
        begin
            for (int k = 0; k < LANES; k++)
            begin
                nx2[k] = NX_W'(ax2[k]);
            end
        end
    end

    // stage 3: divider set-up and tolerance test
    logic signed [WIDE_W-1:0] dsel3;
    logic [WIDE_W-1:0]        dabs3;
    logic                     sing3;
    logic [NX_W-1:0]          nabs3 [LANES];
    div_side_t                side3;

    logic                        s3_vld_reg;
    logic [MAG_W-1:0]            s3_den_reg;
    logic [LANES-1:0][MAG_W-1:0] s3_num_reg;
    div_side_t                   s3_side_reg;

    always_comb
    begin
        dsel3 = s2_cls_reg.divide ? WIDE_W'(s2_b11_reg) : s2_det_reg;
        dabs3 = dsel3[WIDE_W-1] ? -dsel3 : dsel3;
        sing3 = (s2_cls_reg.divide || s2_cls_reg.invert) && (dabs3 <= WIDE_W'(tol));
        side3.use_q = (s2_cls_reg.divide || s2_cls_reg.invert) && !sing3;
        side3.sing  = sing3;
        side3.det   = s2_det_reg;
        for (int k = 0; k < LANES; k++)
        begin
            nabs3[k]       = s2_nx_reg[k][NX_W-1] ? -s2_nx_reg[k] : s2_nx_reg[k];
            side3.lane[k]  = s2_lane_reg[k];
            side3.q_neg[k] = s2_nx_reg[k][NX_W-1] ^ dsel3[WIDE_W-1];
        end
    end

    // division
    logic                        dv_vld;
    logic [LANES-1:0][MAG_W-1:0] dv_quo;
    div_side_t                   dv_side;

    mx2_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s3_vld_reg),
        .in_den    (s3_den_reg),
        .in_num    (s3_num_reg),
        .in_side   (s3_side_reg),
        .out_valid (dv_vld),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    // final: sign, select and clamp
    logic signed [WIDE_W-1:0] qs4 [LANES];
    logic signed [WIDE_W-1:0] v4 [LANES];
    sat_t                     st4 [LANES];
    sat_t                     dst4;
    out_item_t                res4;

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            qs4[k] = dv_side.q_neg[k] ? -WIDE_W'(dv_quo[k]) : WIDE_W'(dv_quo[k]);
            v4[k]  = dv_side.use_q ? qs4[k] : dv_side.lane[k];
            st4[k] = sat_f(v4[k]);
        end
        dst4 = sat_f(dv_side.det);
        res4.r_r1c1    = st4[0].val;
        res4.r_r2c1    = st4[1].val;
        res4.r_r1c2    = st4[2].val;
        res4.r_r2c2    = st4[3].val;
        res4.det_value = dst4.val;
        res4.singular  = dv_side.sing;
        res4.saturated = st4[0].clamp || st4[1].clamp || st4[2].clamp || st4[3].clamp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg    <= q_valid;
            s2_vld_reg    <= s1_vld_reg;
            s3_vld_reg    <= s2_vld_reg;
            out_valid_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_cmd_reg <= q_cmd;
            for (int k = 0; k < LANES; k++)
            begin
                s1_pa_reg[k] <= PROD_W'(fa[k]) * PROD_W'(fb[k]);
                s1_pb_reg[k] <= PROD_W'(ga[k]) * PROD_W'(gb[k]);
            end
            s1_pd1_reg <= PROD_W'(q_cmd.item.a_r1c1) * PROD_W'(q_cmd.item.a_r2c2);
            s1_pd2_reg <= PROD_W'(q_cmd.item.a_r1c2) * PROD_W'(q_cmd.item.a_r2c1);

            s2_cls_reg <= c2;
            s2_b11_reg <= it2.b_r1c1;
            s2_det_reg <= det2;
            for (int k = 0; k < LANES; k++)
            begin
                s2_lane_reg[k] <= lane2[k];
                s2_nx_reg[k]   <= nx2[k];
            end

            s3_den_reg  <= dabs3[MAG_W-1:0];
            s3_side_reg <= side3;
            for (int k = 0; k < LANES; k++)
            begin
                s3_num_reg[k] <= {nabs3[k][NX_W-2:0], {FRAC_W{1'b0}}};
            end

            out_data_reg <= res4;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> rtl/matrix2x2_arith_unit.sv
// Top level of the 2x2 Q16.16 matrix arithmetic unit.
// One request per cycle is taken and one result per cycle is given while the
// queue is not full and the output is not stalled. A request goes into a
// four-entry queue; its products are formed as it leaves the queue, then come
// the sums, the divider set-up, the pipelined restoring divider (one quotient
// bit per stage, four lanes) and the output register.
// Every operation takes the same path, so results leave in request order. A
// stall on a valid output freezes the whole execution pipeline; the queue keeps
// accepting until it is full. zero_tolerance is to be written on the cfg port
// only while the unit is idle; the block itself does not enforce this.
module matrix2x2_arith_unit import mx2_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [TOL_W-1:0] cfg_data
);

    logic [TOL_W-1:0] tol_reg;
    logic             push;
    cmd_t             cmd;
    logic             q_full;
    logic             q_valid;
    cmd_t             q_cmd;
    logic             pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            tol_reg <= cfg_data;
        end
    end

    mx2_front u_front
    (
        .in_valid (in_valid),
        .in_data  (in_data),
        .in_stall (in_stall),
        .q_full   (q_full),
        .push     (push),
        .cmd      (cmd)
    );

    mx2_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (cmd),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_cmd)
    );

    mx2_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .tol       (tol_reg),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .pop       (pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // a singular result is A unchanged, so nothing can clamp
    a_sing_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.singular |-> !out_data.saturated)
        else $error("singular result flagged as saturated");

    // queued request must move on whenever the output is free
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && !(out_valid && out_stall) |-> pop)
        else $error("queued request held with output free");

    // queue full only when the pipeline has been held
    a_full_held: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(q_full) |-> $past(push) && !$past(pop))
        else $error("queue filled without a held pipeline");

endmodule
